### sv/pso_pkg.sv
// Shared types, widths, register codes and saturation helper for the particle update pipeline.
`timescale 1ns / 1ps

package pso_pkg;

   localparam int WORD_W      = 32;
   localparam int RAND_W      = 16;
   localparam int GAIN_W      = 18;
   localparam int LIMIT_W     = 31;
   localparam int FRAC_W      = 16;
   localparam int CSR_DATA_W  = 31;
   localparam int CSR_INDEX_W = 2;
   localparam int DIFF_W      = WORD_W + 1;
   localparam int PROD_W      = DIFF_W + GAIN_W + 1;
   localparam int TERM_W      = PROD_W - FRAC_W;
   localparam int SUM_W       = WORD_W + 2;

   localparam logic [GAIN_W-1:0]  INERTIA_GAIN_RESET   = 18'd45875;
   localparam logic [GAIN_W-1:0]  COGNITIVE_GAIN_RESET = 18'd98304;
   localparam logic [GAIN_W-1:0]  SOCIAL_GAIN_RESET    = 18'd98304;
   localparam logic [LIMIT_W-1:0] VELOCITY_LIMIT_RESET = 31'd655360;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INERTIA_GAIN   = 2'd0,
      CSR_COGNITIVE_GAIN = 2'd1,
      CSR_SOCIAL_GAIN    = 2'd2,
      CSR_VELOCITY_LIMIT = 2'd3
   } pso_csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  inertia_gain;
      logic [GAIN_W-1:0]  cognitive_gain;
      logic [GAIN_W-1:0]  social_gain;
      logic [LIMIT_W-1:0] velocity_limit;
   } pso_cfg_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] position;
      logic signed [WORD_W-1:0] velocity;
      logic signed [WORD_W-1:0] own_best;
      logic signed [WORD_W-1:0] swarm_best;
      logic [RAND_W-1:0]        rand_cognitive;
      logic [RAND_W-1:0]        rand_social;
      logic signed [WORD_W-1:0] lower_bound;
      logic signed [WORD_W-1:0] upper_bound;
   } pso_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] new_velocity;
      logic signed [WORD_W-1:0] new_position;
   } pso_rsp_type;

   // Full-precision products of the three velocity terms plus the bounds context.
   typedef struct packed {
      logic signed [PROD_W-1:0] inertia_prod;
      logic signed [PROD_W-1:0] cognitive_prod;
      logic signed [PROD_W-1:0] social_prod;
      logic signed [WORD_W-1:0] position;
      logic signed [WORD_W-1:0] lower_bound;
      logic signed [WORD_W-1:0] upper_bound;
   } pso_prod_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] velocity;
      logic signed [WORD_W-1:0] position;
      logic signed [WORD_W-1:0] lower_bound;
      logic signed [WORD_W-1:0] upper_bound;
   } pso_vel_type;

   // Saturates a signed value to the signed word range.
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [TERM_W-1:0] x);
      logic [TERM_W-WORD_W:0]   top_bits;
      logic signed [WORD_W-1:0] result;
      top_bits = x[TERM_W-1:WORD_W-1];
      if (top_bits == '0 || top_bits == '1) begin
         result = x[WORD_W-1:0];
      end else if (x[TERM_W-1]) begin
         result = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(WORD_W-1){1'b1}}};
      end
      return result;
   endfunction

endpackage

### sv/pso_particle_update.sv
// Top level of the particle swarm velocity and position update pipeline.
`timescale 1ns / 1ps

// This block updates one particle dimension per request: the new velocity is
// inertia*v + cognitive*r1*(own_best-x) + social*r2*(swarm_best-x), each term
// and the sum saturated to 32 bits, then clamped to plus or minus the velocity
// limit; the new position is x plus that velocity, clamped to the bounds, with
// the upper bound taking precedence. It is a five-stage pipeline (random
// weights and differences, three parallel multipliers, term sum, velocity
// clamp, position clamp into the output register), which takes one request
// every cycle unless back-pressure from a stalled response reaches it. A stalled
// response holds the output register and back-pressure ripples stage by stage,
// so empty stages still fill while rsp_ready is low. The gains and the limit
// are written through the csr port and should only change while the pipeline
// is empty.

module pso_particle_update (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pso_pkg::pso_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pso_pkg::pso_rsp_type                 rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [pso_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pso_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import pso_pkg::*;

   logic [GAIN_W-1:0]  inertia_gain_ff, inertia_gain_in;
   logic [GAIN_W-1:0]  cognitive_gain_ff, cognitive_gain_in;
   logic [GAIN_W-1:0]  social_gain_ff, social_gain_in;
   logic [LIMIT_W-1:0] velocity_limit_ff, velocity_limit_in;
   pso_cfg_type        cfg;

   logic               prod_valid, prod_ready;
   pso_prod_type       prod_data;
   logic               vel_valid, vel_ready;
   pso_vel_type        vel_data;

   // Register file. Writes to any index take effect on the next cycle.
   always_comb begin
      inertia_gain_in   = inertia_gain_ff;
      cognitive_gain_in = cognitive_gain_ff;
      social_gain_in    = social_gain_ff;
      velocity_limit_in = velocity_limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INERTIA_GAIN:   inertia_gain_in   = csr_wdata[GAIN_W-1:0];
            CSR_COGNITIVE_GAIN: cognitive_gain_in = csr_wdata[GAIN_W-1:0];
            CSR_SOCIAL_GAIN:    social_gain_in    = csr_wdata[GAIN_W-1:0];
            CSR_VELOCITY_LIMIT: velocity_limit_in = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inertia_gain_ff   <= INERTIA_GAIN_RESET;
         cognitive_gain_ff <= COGNITIVE_GAIN_RESET;
         social_gain_ff    <= SOCIAL_GAIN_RESET;
         velocity_limit_ff <= VELOCITY_LIMIT_RESET;
      end else begin
         inertia_gain_ff   <= inertia_gain_in;
         cognitive_gain_ff <= cognitive_gain_in;
         social_gain_ff    <= social_gain_in;
         velocity_limit_ff <= velocity_limit_in;
      end
   end

   assign cfg.inertia_gain   = inertia_gain_ff;
   assign cfg.cognitive_gain = cognitive_gain_ff;
   assign cfg.social_gain    = social_gain_ff;
   assign cfg.velocity_limit = velocity_limit_ff;

   // Stages one and two: weights, differences and the three products.
   pso_term_mult u_term_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   // Stage three: rounding, term saturation and the saturated sum.
   pso_term_sum u_term_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (vel_valid),
      .out_ready (vel_ready),
      .out_data  (vel_data)
   );

   // Stages four and five: velocity clamp, then position update into the output register.
   pso_bound_clamp u_bound_clamp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (vel_valid),
      .in_ready  (vel_ready),
      .in_data   (vel_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // Back-pressure can only originate from a response waiting at the output.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled while the output side was free");

   // Every delivered velocity respects the configured limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_data.new_velocity) <= $signed({1'b0, velocity_limit_ff})
                 && $signed(rsp_data.new_velocity) >= -$signed({1'b0, velocity_limit_ff})))
      else $error("response velocity outside the limit");

   // A response waiting for the receiver holds still until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("waiting response changed before it was taken");
`endif

endmodule

### sv/pso_term_mult.sv
// Two pipeline stages: random weights and differences, then the three term products.
`timescale 1ns / 1ps

module pso_term_mult (
   input  logic                  clock,
   input  logic                  reset,
   input  pso_pkg::pso_cfg_type  cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pso_pkg::pso_req_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pso_pkg::pso_prod_type out_data
);
   import pso_pkg::*;

   typedef struct packed {
      logic signed [WORD_W-1:0] velocity;
      logic signed [DIFF_W-1:0] cognitive_diff;
      logic signed [DIFF_W-1:0] social_diff;
      logic [GAIN_W-1:0]        cognitive_weight;
      logic [GAIN_W-1:0]        social_weight;
      logic signed [WORD_W-1:0] position;
      logic signed [WORD_W-1:0] lower_bound;
      logic signed [WORD_W-1:0] upper_bound;
   } pso_diff_type;

   logic                       s1_valid_ff, s1_valid_in;
   pso_diff_type               s1_data_ff, s1_data_in;
   logic                       s2_valid_ff, s2_valid_in;
   pso_prod_type               s2_data_ff, s2_data_in;
   logic                       s1_adv, s2_adv;
   logic [GAIN_W+RAND_W-1:0]   cognitive_full;
   logic [GAIN_W+RAND_W-1:0]   social_full;

   assign s2_adv   = !s2_valid_ff || out_ready;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;

   always_comb begin
      cognitive_full = cfg.cognitive_gain * in_data.rand_cognitive;
      social_full    = cfg.social_gain * in_data.rand_social;
      s1_valid_in    = s1_adv ? in_valid : s1_valid_ff;
      s1_data_in     = s1_data_ff;
      if (s1_adv && in_valid) begin
         s1_data_in.velocity         = in_data.velocity;
         s1_data_in.cognitive_diff   = $signed({in_data.own_best[WORD_W-1], in_data.own_best})
                                     - $signed({in_data.position[WORD_W-1], in_data.position});
         s1_data_in.social_diff      = $signed({in_data.swarm_best[WORD_W-1], in_data.swarm_best})
                                     - $signed({in_data.position[WORD_W-1], in_data.position});
         s1_data_in.cognitive_weight = cognitive_full[GAIN_W+RAND_W-1:FRAC_W];
         s1_data_in.social_weight    = social_full[GAIN_W+RAND_W-1:FRAC_W];
         s1_data_in.position         = in_data.position;
         s1_data_in.lower_bound      = in_data.lower_bound;
         s1_data_in.upper_bound      = in_data.upper_bound;
      end
   end

   always_comb begin
      s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
      s2_data_in  = s2_data_ff;
      if (s2_adv && s1_valid_ff) begin
         s2_data_in.inertia_prod   = $signed(s1_data_ff.velocity)
                                   * $signed({1'b0, cfg.inertia_gain});
         s2_data_in.cognitive_prod = $signed(s1_data_ff.cognitive_diff)
                                   * $signed({1'b0, s1_data_ff.cognitive_weight});
         s2_data_in.social_prod    = $signed(s1_data_ff.social_diff)
                                   * $signed({1'b0, s1_data_ff.social_weight});
         s2_data_in.position       = s1_data_ff.position;
         s2_data_in.lower_bound    = s1_data_ff.lower_bound;
         s2_data_in.upper_bound    = s1_data_ff.upper_bound;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s2_data_ff <= s2_data_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

### sv/pso_term_sum.sv
// One pipeline stage: scales, saturates and adds the three velocity terms.
`timescale 1ns / 1ps

module pso_term_sum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pso_pkg::pso_prod_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pso_pkg::pso_vel_type  out_data
);
   import pso_pkg::*;

   logic                     valid_ff, valid_in;
   pso_vel_type              data_ff, data_in;
   logic                     adv;
   logic signed [WORD_W-1:0] inertia_term;
   logic signed [WORD_W-1:0] cognitive_term;
   logic signed [WORD_W-1:0] social_term;
   logic signed [SUM_W-1:0]  term_sum;

   assign adv      = !valid_ff || out_ready;
   assign in_ready = adv;

   always_comb begin
      // Dropping the fraction bits of a signed product rounds toward minus infinity.
      inertia_term   = sat_word($signed(in_data.inertia_prod[PROD_W-1:FRAC_W]));
      cognitive_term = sat_word($signed(in_data.cognitive_prod[PROD_W-1:FRAC_W]));
      social_term    = sat_word($signed(in_data.social_prod[PROD_W-1:FRAC_W]));
      term_sum = $signed({{2{inertia_term[WORD_W-1]}}, inertia_term})
               + $signed({{2{cognitive_term[WORD_W-1]}}, cognitive_term})
               + $signed({{2{social_term[WORD_W-1]}}, social_term});
      valid_in = adv ? in_valid : valid_ff;
      data_in  = data_ff;
      if (adv && in_valid) begin
         data_in.velocity    = sat_word($signed({{(TERM_W-SUM_W){term_sum[SUM_W-1]}}, term_sum}));
         data_in.position    = in_data.position;
         data_in.lower_bound = in_data.lower_bound;
         data_in.upper_bound = in_data.upper_bound;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### sv/pso_bound_clamp.sv
// Two pipeline stages: velocity limit clamp, then position update and bounds clamp.
`timescale 1ns / 1ps

module pso_bound_clamp (
   input  logic                 clock,
   input  logic                 reset,
   input  pso_pkg::pso_cfg_type cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pso_pkg::pso_vel_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pso_pkg::pso_rsp_type out_data
);
   import pso_pkg::*;

   logic                     s4_valid_ff, s4_valid_in;
   pso_vel_type              s4_data_ff, s4_data_in;
   logic                     s5_valid_ff, s5_valid_in;
   pso_rsp_type              s5_data_ff, s5_data_in;
   logic                     s4_adv, s5_adv;
   logic signed [WORD_W-1:0] limit_pos;
   logic signed [WORD_W-1:0] limit_neg;
   logic signed [WORD_W:0]   pos_sum;
   logic signed [WORD_W:0]   upper_ext;
   logic signed [WORD_W:0]   lower_ext;

   assign s5_adv   = !s5_valid_ff || out_ready;
   assign s4_adv   = !s4_valid_ff || s5_adv;
   assign in_ready = s4_adv;

   always_comb begin
      limit_pos   = $signed({1'b0, cfg.velocity_limit});
      limit_neg   = -limit_pos;
      s4_valid_in = s4_adv ? in_valid : s4_valid_ff;
      s4_data_in  = s4_data_ff;
      if (s4_adv && in_valid) begin
         s4_data_in = in_data;
         if (in_data.velocity > limit_pos) begin
            s4_data_in.velocity = limit_pos;
         end else if (in_data.velocity < limit_neg) begin
            s4_data_in.velocity = limit_neg;
         end
      end
   end

   always_comb begin
      pos_sum   = $signed({s4_data_ff.position[WORD_W-1], s4_data_ff.position})
                + $signed({s4_data_ff.velocity[WORD_W-1], s4_data_ff.velocity});
      upper_ext = $signed({s4_data_ff.upper_bound[WORD_W-1], s4_data_ff.upper_bound});
      lower_ext = $signed({s4_data_ff.lower_bound[WORD_W-1], s4_data_ff.lower_bound});
      s5_valid_in = s5_adv ? s4_valid_ff : s5_valid_ff;
      s5_data_in  = s5_data_ff;
      if (s5_adv && s4_valid_ff) begin
         s5_data_in.new_velocity = s4_data_ff.velocity;
         // The upper test wins, which also settles crossed bounds.
         if (pos_sum >= upper_ext) begin
            s5_data_in.new_position = s4_data_ff.upper_bound;
         end else if (pos_sum <= lower_ext) begin
            s5_data_in.new_position = s4_data_ff.lower_bound;
         end else begin
            s5_data_in.new_position = pos_sum[WORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s4_data_ff <= s4_data_in;
      s5_data_ff <= s5_data_in;
   end

   assign out_valid = s5_valid_ff;
   assign out_data  = s5_data_ff;

endmodule
